>>> hw/rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared widths, codes and beat descriptor of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int MAX_TEXELS_DEF = 65536;
  localparam int COORD_FRAC_DEF = 16;

  localparam int COORD_W    = 18;
  localparam int DIM_W      = 13;
  localparam int CH_W       = 8;
  localparam int TEXEL_W    = 32;
  localparam int INDEX_W    = 16;
  localparam int CC_W       = 3;
  localparam int LIN_W      = 26;
  localparam int WGT_W      = 17;
  localparam int WGT_SHIFT  = 16;
  localparam int ACC_W      = 24;
  localparam int SUM_W      = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [11:0] DIV3_MUL   = 12'd1366;
  localparam int          DIV3_SHIFT = 12;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH      = 8'd0,
    REG_TEX_HEIGHT     = 8'd1,
    REG_CHANNEL_COUNT  = 8'd2,
    REG_TEXTURE_LOADED = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic               wr;
    logic               first;
    logic               last;
    logic [1:0]         corner;
    logic               bilinear;
    logic [CH_W-1:0]    dflt;
    logic [INDEX_W-1:0] index;
    logic [TEXEL_W-1:0] wdata;
  } beat_t;

  function automatic int addr_bits(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

>>> hw/rtl/bts_if.sv
// ----------------------------------------------------------------------------
// bts_if
// Handshake channels of the bilinear texture sampler: items, results, config.
// ----------------------------------------------------------------------------
interface bts_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [bts_pkg::INDEX_W-1:0]         texel_index;
  logic [bts_pkg::CH_W-1:0]            in_red;
  logic [bts_pkg::CH_W-1:0]            in_green;
  logic [bts_pkg::CH_W-1:0]            in_blue;
  logic [bts_pkg::CH_W-1:0]            in_alpha;
  logic signed [bts_pkg::COORD_W-1:0]  coord_u;
  logic signed [bts_pkg::COORD_W-1:0]  coord_v;
  logic                                filter_bilinear;
  logic [bts_pkg::CH_W-1:0]            default_level;

  modport source (output valid, operation, texel_index, in_red, in_green, in_blue,
                  in_alpha, coord_u, coord_v, filter_bilinear, default_level,
                  input ready);
  modport sink (input valid, operation, texel_index, in_red, in_green, in_blue,
                in_alpha, coord_u, coord_v, filter_bilinear, default_level,
                output ready);
endinterface

interface bts_out_if;
  logic                     valid;
  logic                     ready;
  logic [bts_pkg::CH_W-1:0] out_red;
  logic [bts_pkg::CH_W-1:0] out_green;
  logic [bts_pkg::CH_W-1:0] out_blue;
  logic [bts_pkg::CH_W-1:0] out_alpha;
  logic [bts_pkg::CH_W-1:0] mean_level;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, mean_level,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, mean_level,
                output ready);
endinterface

interface bts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bts_pkg::CFG_IDX_W-1:0]  index;
  logic [bts_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bts_addr.sv
// ----------------------------------------------------------------------------
// bts_addr
// Six-stage address path: clamp, scale, corner select, linearize, wrap.
// ----------------------------------------------------------------------------
module bts_addr #(
  parameter int MAX_TEXELS      = bts_pkg::MAX_TEXELS_DEF,
  parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              adv,
  input  logic                                              in_valid,
  input  bts_pkg::beat_t                                    in_beat,
  input  logic signed [bts_pkg::COORD_W-1:0]                in_u,
  input  logic signed [bts_pkg::COORD_W-1:0]                in_v,
  input  logic [bts_pkg::DIM_W-1:0]                         wm1,
  input  logic [bts_pkg::DIM_W-1:0]                         hm1,
  input  logic [bts_pkg::DIM_W-1:0]                         weff,
  output logic                                              out_valid,
  output bts_pkg::beat_t                                    out_beat,
  output logic [bts_pkg::addr_bits(MAX_TEXELS)-1:0]         out_addr,
  output logic                                              out_wr_en,
  output logic [bts_pkg::WGT_W-1:0]                         out_wgt
);

  localparam int ADDR_W = bts_pkg::addr_bits(MAX_TEXELS);
  localparam int CW     = bts_pkg::COORD_W;
  localparam int DW     = bts_pkg::DIM_W;
  localparam int LW     = bts_pkg::LIN_W;
  localparam int F      = COORD_FRAC_BITS;
  localparam int UW     = F + 1;
  localparam int FXW    = UW + DW;
  localparam int SHIFT  = LW + $clog2(MAX_TEXELS);
  localparam int PW     = LW + LW + 1;

  localparam logic [UW-1:0]  ONE        = {1'b1, {F{1'b0}}};
  localparam logic [FXW-1:0] HALF       = FXW'(1) << (F - 1);
  localparam logic [63:0]    RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(MAX_TEXELS) - 64'd1) / 64'(MAX_TEXELS);
  localparam logic [LW:0]    RECIP      = RECIP_FULL[LW:0];
  localparam logic [LW-1:0]  MOD        = LW'(MAX_TEXELS);

  function automatic logic [UW-1:0] clamp_coord(logic signed [CW-1:0] raw);
    logic [31:0]   mag;
    logic [UW-1:0] res;
    mag = 32'(raw[CW-2:0]);
    if (raw[CW-1]) begin
      res = '0;
    end else if (mag > 32'(ONE)) begin
      res = ONE;
    end else begin
      res = UW'(mag);
    end
    return res;
  endfunction

  logic [5:0]           vld_r;
  bts_pkg::beat_t       bt_r [6];

  logic [UW-1:0]        u1_r, v1_r;
  logic [FXW-1:0]       fx2_r, fy2_r;
  logic [DW-1:0]        x3_r, y3_r;
  logic [8:0]           wx3_r, wy3_r;
  logic [LW-1:0]        lin4_r, lin5_r;
  logic [bts_pkg::WGT_W-1:0] wgt4_r, wgt5_r, wgt6_r;
  logic [LW-1:0]        q5_r;
  logic [ADDR_W-1:0]    addr6_r;
  logic                 wr_en6_r;

  logic [DW-1:0]        x0, y0, x1, y1, xn, yn, x_sel, y_sel;
  logic [7:0]           dx, dy;
  logic [8:0]           wx_sel, wy_sel;
  logic [PW-1:0]        prod5;
  logic [LW-1:0]        rem6;

  always_comb begin
    x0 = DW'(fx2_r >> F);
    y0 = DW'(fy2_r >> F);
    xn = DW'((fx2_r + HALF) >> F);
    yn = DW'((fy2_r + HALF) >> F);
    x1 = (x0 == wm1) ? wm1 : x0 + DW'(1);
    y1 = (y0 == hm1) ? hm1 : y0 + DW'(1);
    dx = fx2_r[F-1 -: 8];
    dy = fy2_r[F-1 -: 8];
    if (bt_r[1].bilinear) begin
      x_sel  = bt_r[1].corner[0] ? x1 : x0;
      y_sel  = bt_r[1].corner[1] ? y1 : y0;
      wx_sel = bt_r[1].corner[0] ? {1'b0, dx} : 9'd256 - {1'b0, dx};
      wy_sel = bt_r[1].corner[1] ? {1'b0, dy} : 9'd256 - {1'b0, dy};
    end else begin
      x_sel  = xn;
      y_sel  = yn;
      wx_sel = 9'd256;
      wy_sel = 9'd256;
    end
  end

  assign prod5 = PW'(lin4_r) * PW'(RECIP);
  assign rem6  = lin5_r - LW'(q5_r * MOD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bt_r[0] <= in_beat;
      for (int i = 1; i < 6; i++) begin
        bt_r[i] <= bt_r[i-1];
      end
      u1_r     <= clamp_coord(in_u);
      v1_r     <= clamp_coord(in_v);
      fx2_r    <= FXW'(u1_r) * FXW'(wm1);
      fy2_r    <= FXW'(v1_r) * FXW'(hm1);
      x3_r     <= x_sel;
      y3_r     <= y_sel;
      wx3_r    <= wx_sel;
      wy3_r    <= wy_sel;
      lin4_r   <= LW'(x3_r) + LW'(y3_r) * LW'(weff);
      wgt4_r   <= bts_pkg::WGT_W'(bts_pkg::WGT_W'(wx3_r) * bts_pkg::WGT_W'(wy3_r));
      lin5_r   <= lin4_r;
      q5_r     <= LW'(prod5 >> SHIFT);
      wgt5_r   <= wgt4_r;
      addr6_r  <= bt_r[4].wr ? ADDR_W'(bt_r[4].index) : ADDR_W'(rem6);
      wr_en6_r <= bt_r[4].wr && (32'(bt_r[4].index) < 32'(MAX_TEXELS));
      wgt6_r   <= wgt5_r;
    end
  end

  assign out_valid = vld_r[5];
  assign out_beat  = bt_r[5];
  assign out_addr  = addr6_r;
  assign out_wr_en = wr_en6_r;
  assign out_wgt   = wgt6_r;

endmodule

>>> hw/rtl/bilinear_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_unit
// Texel store and sampler: nearest or bilinear lookup with channel mean.
// ----------------------------------------------------------------------------
// Throughput: write or nearest sample 1 item/cycle while results are taken;
//   a bilinear sample holds the input for one beat per corner, set by the
//   single port of the texel memory (one read per corner).
// Reset: config registers take width 1, height 1, four channels, no texture;
//   pipeline valids clear; texel memory is not cleared.
module bilinear_texture_sampler_unit #(
  parameter int MAX_TEXELS      = bts_pkg::MAX_TEXELS_DEF,
  parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bts_in_if.sink    in_chan,
  bts_out_if.source out_chan,
  bts_cfg_if.sink   cfg_chan
);

  localparam int ADDR_W = bts_pkg::addr_bits(MAX_TEXELS);
  localparam int DW     = bts_pkg::DIM_W;
  localparam int CH     = bts_pkg::CH_W;
  localparam int AW     = bts_pkg::ACC_W;
  localparam int SW     = bts_pkg::SUM_W;
  localparam int P3W    = SW + 12;

  localparam logic [AW:0] RND = (AW+1)'(1) << (bts_pkg::WGT_SHIFT - 1);

  logic [DW-1:0]             tex_width_r, tex_height_r;
  logic [bts_pkg::CC_W-1:0]  chan_cnt_r;
  logic                      loaded_r;
  logic [DW-1:0]             weff, wm1, hm1;

  logic                      adv;
  logic                      in_ready;

  logic                      p0_valid_r;
  logic                      p0_wr_r;
  logic                      p0_bil_r;
  logic [bts_pkg::INDEX_W-1:0] p0_index_r;
  logic [bts_pkg::TEXEL_W-1:0] p0_wdata_r;
  logic signed [bts_pkg::COORD_W-1:0] p0_u_r, p0_v_r;
  logic [CH-1:0]             p0_dflt_r;
  logic [1:0]                cnt_r;
  logic                      p0_last;
  logic [bts_pkg::TEXEL_W-1:0] wdata_in;
  bts_pkg::beat_t            p0_beat;

  logic                      a6_valid;
  bts_pkg::beat_t            a6_beat;
  logic [ADDR_W-1:0]         a6_addr;
  logic                      a6_wr_en;
  logic [bts_pkg::WGT_W-1:0] a6_wgt;

  logic [bts_pkg::TEXEL_W-1:0] mem [MAX_TEXELS];
  logic [bts_pkg::TEXEL_W-1:0] rdata_r;
  logic                      m_valid_r;
  bts_pkg::beat_t            m_beat_r;
  logic [bts_pkg::WGT_W-1:0] m_wgt_r;

  logic [AW-1:0]             acc_r [4];
  logic [AW-1:0]             acc_nxt [4];
  logic                      s8_valid_r;
  logic [CH-1:0]             s8_dflt_r;

  logic [CH-1:0]             res [4];
  logic [SW-1:0]             sum;
  logic [AW:0]               rnd_tmp [4];
  logic                      s9_valid_r;
  logic [CH-1:0]             s9_res_r [4];
  logic [SW-1:0]             s9_sum_r;
  logic [CH-1:0]             s9_dflt_r;

  logic [P3W-1:0]            prod3;
  logic [CH-1:0]             mean;
  logic                      out_valid_r;
  logic [CH-1:0]             out_res_r [4];
  logic [CH-1:0]             out_mean_r;

  // configuration
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= DW'(1);
      tex_height_r <= DW'(1);
      chan_cnt_r   <= bts_pkg::CC_W'(4);
      loaded_r     <= 1'b0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        bts_pkg::REG_TEX_WIDTH:      tex_width_r  <= cfg_chan.data[DW-1:0];
        bts_pkg::REG_TEX_HEIGHT:     tex_height_r <= cfg_chan.data[DW-1:0];
        bts_pkg::REG_CHANNEL_COUNT:  chan_cnt_r   <= cfg_chan.data[bts_pkg::CC_W-1:0];
        bts_pkg::REG_TEXTURE_LOADED: loaded_r     <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  assign weff = (tex_width_r == '0) ? DW'(1) : tex_width_r;
  assign wm1  = (tex_width_r == '0) ? '0 : tex_width_r - DW'(1);
  assign hm1  = (tex_height_r == '0) ? '0 : tex_height_r - DW'(1);

  // item stage and corner sequencer
  assign adv      = !out_valid_r || out_chan.ready;
  assign p0_last  = p0_wr_r || !p0_bil_r || (cnt_r == 2'd3);
  assign in_ready = adv && (!p0_valid_r || p0_last);
  assign in_chan.ready = in_ready;

  always_comb begin
    wdata_in = {in_chan.in_alpha, in_chan.in_blue, in_chan.in_green, in_chan.in_red};
    for (int c = 0; c < 4; c++) begin
      if (chan_cnt_r <= bts_pkg::CC_W'(c)) begin
        wdata_in[c*CH +: CH] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_valid_r <= 1'b0;
      cnt_r      <= '0;
    end else if (adv) begin
      if (p0_valid_r) begin
        cnt_r <= p0_last ? 2'd0 : cnt_r + 2'd1;
      end
      if (!p0_valid_r || p0_last) begin
        p0_valid_r <= in_chan.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_ready) begin
      p0_wr_r    <= (in_chan.operation == bts_pkg::OP_WRITE);
      p0_bil_r   <= in_chan.filter_bilinear;
      p0_index_r <= in_chan.texel_index;
      p0_wdata_r <= wdata_in;
      p0_u_r     <= in_chan.coord_u;
      p0_v_r     <= in_chan.coord_v;
      p0_dflt_r  <= in_chan.default_level;
    end
  end

  always_comb begin
    p0_beat.wr       = p0_wr_r;
    p0_beat.first    = (cnt_r == 2'd0);
    p0_beat.last     = p0_last;
    p0_beat.corner   = cnt_r;
    p0_beat.bilinear = p0_bil_r;
    p0_beat.dflt     = p0_dflt_r;
    p0_beat.index    = p0_index_r;
    p0_beat.wdata    = p0_wdata_r;
  end

  bts_addr #(
    .MAX_TEXELS      (MAX_TEXELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p0_valid_r),
    .in_beat   (p0_beat),
    .in_u      (p0_u_r),
    .in_v      (p0_v_r),
    .wm1       (wm1),
    .hm1       (hm1),
    .weff      (weff),
    .out_valid (a6_valid),
    .out_beat  (a6_beat),
    .out_addr  (a6_addr),
    .out_wr_en (a6_wr_en),
    .out_wgt   (a6_wgt)
  );

  // texel memory
  always_ff @(posedge clk) begin
    if (adv) begin
      if (a6_valid && a6_wr_en) begin
        mem[a6_addr] <= a6_beat.wdata;
      end
      rdata_r <= mem[a6_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= a6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_beat_r <= a6_beat;
      m_wgt_r  <= a6_wgt;
    end
  end

  // corner accumulation
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_nxt[c] = (m_beat_r.first ? AW'(0) : acc_r[c])
                 + AW'(AW'(rdata_r[c*CH +: CH]) * AW'(m_wgt_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_valid_r <= 1'b0;
    end else if (adv) begin
      s8_valid_r <= m_valid_r && !m_beat_r.wr && m_beat_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && m_valid_r && !m_beat_r.wr) begin
      for (int c = 0; c < 4; c++) begin
        acc_r[c] <= acc_nxt[c];
      end
      s8_dflt_r <= m_beat_r.dflt;
    end
  end

  // rounding and channel sum
  always_comb begin
    sum = SW'(chan_cnt_r >> 1);
    for (int c = 0; c < 4; c++) begin
      rnd_tmp[c] = {1'b0, acc_r[c]} + RND;
      if (loaded_r) begin
        res[c] = CH'(rnd_tmp[c] >> bts_pkg::WGT_SHIFT);
      end else if (chan_cnt_r > bts_pkg::CC_W'(c)) begin
        res[c] = s8_dflt_r;
      end else begin
        res[c] = '0;
      end
      if (chan_cnt_r > bts_pkg::CC_W'(c)) begin
        sum = sum + SW'(res[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_valid_r <= 1'b0;
    end else if (adv) begin
      s9_valid_r <= s8_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s8_valid_r) begin
      for (int c = 0; c < 4; c++) begin
        s9_res_r[c] <= res[c];
      end
      s9_sum_r  <= sum;
      s9_dflt_r <= s8_dflt_r;
    end
  end

  // mean over used channels
  assign prod3 = P3W'(s9_sum_r) * P3W'(bts_pkg::DIV3_MUL);

  always_comb begin
    case (chan_cnt_r)
      3'd1:    mean = CH'(s9_sum_r);
      3'd2:    mean = CH'(s9_sum_r >> 1);
      3'd3:    mean = CH'(prod3 >> bts_pkg::DIV3_SHIFT);
      3'd4:    mean = CH'(s9_sum_r >> 2);
      default: mean = s9_dflt_r;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s9_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s9_valid_r) begin
      for (int c = 0; c < 4; c++) begin
        out_res_r[c] <= s9_res_r[c];
      end
      out_mean_r <= mean;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_red    = out_res_r[0];
  assign out_chan.out_green  = out_res_r[1];
  assign out_chan.out_blue   = out_res_r[2];
  assign out_chan.out_alpha  = out_res_r[3];
  assign out_chan.mean_level = out_mean_r;

endmodule

>>> hw/rtl/bts_checker.sv
// ----------------------------------------------------------------------------
// bts_checker
// Port-level checks of the texture sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_operation,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [bts_pkg::CH_W-1:0] out_red,
  input logic [bts_pkg::CH_W-1:0] out_green,
  input logic [bts_pkg::CH_W-1:0] out_blue,
  input logic [bts_pkg::CH_W-1:0] out_alpha,
  input logic [bts_pkg::CH_W-1:0] mean_level
);

  logic [4:0] pending_r;
  logic       smp_acc;
  logic       res_acc;

  assign smp_acc = in_valid && in_ready && (in_operation == bts_pkg::OP_SAMPLE);
  assign res_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 5'(smp_acc) - 5'(res_acc);
    end
  end

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
      $stable(out_blue) && $stable(out_alpha) && $stable(mean_level))
    else $error("result payload changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result path stalled");

  a_result_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 5'd0)
    else $error("result without an outstanding sample");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bilinear_texture_sampler_unit bts_checker u_bts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_operation (in_chan.operation),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_red      (out_chan.out_red),
  .out_green    (out_chan.out_green),
  .out_blue     (out_chan.out_blue),
  .out_alpha    (out_chan.out_alpha),
  .mean_level   (out_chan.mean_level)
);
